/* hdl/gwb_pkg.sv */
// ----------------------------------------------------------------------------
// gwb_pkg
// Types, constants and codes shared by the gray-world white balance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwb_pkg;

   localparam int unsigned NUM_CHAN       = 3;
   localparam int unsigned CHAN_IDX_WIDTH = 2;
   localparam int unsigned PIX_WIDTH      = 8;
   localparam int unsigned SUM_WIDTH      = 28;
   localparam int unsigned GAIN_WIDTH     = 20;
   localparam int unsigned GAIN_FRAC_BITS = 12;
   localparam int unsigned MAX_PIXELS     = 1048576;
   localparam int unsigned PROD_WIDTH     = PIX_WIDTH + GAIN_WIDTH;
   localparam int unsigned SCALED_WIDTH   = PROD_WIDTH - GAIN_FRAC_BITS;

   // restoring divider: dividend is max_sum scaled by the gain fraction
   localparam int unsigned DIV_STEPS      = SUM_WIDTH + GAIN_FRAC_BITS;
   localparam int unsigned CNT_WIDTH      = $clog2(DIV_STEPS);

   localparam longint unsigned PIX_MAX_L   = (64'd1 << PIX_WIDTH) - 64'd1;
   localparam longint unsigned FRAME_CAP   = longint'(MAX_PIXELS) * PIX_MAX_L;
   localparam longint unsigned SUM_FIELD_MAX = (64'd1 << SUM_WIDTH) - 64'd1;

   localparam logic [SUM_WIDTH-1:0] SUM_CAP =
      SUM_WIDTH'((FRAME_CAP < SUM_FIELD_MAX) ? FRAME_CAP : SUM_FIELD_MAX);
   localparam logic [GAIN_WIDTH-1:0] GAIN_MAX   = '1;
   localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = GAIN_WIDTH'(64'd1 << GAIN_FRAC_BITS);
   localparam logic [PIX_WIDTH-1:0]  PIX_MAX    = '1;

   localparam logic [CHAN_IDX_WIDTH-1:0] LAST_CHAN = CHAN_IDX_WIDTH'(NUM_CHAN - 1);

   // pass codes carried in the op field
   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_APPLY = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [PIX_WIDTH-1:0] chan0;
      logic [PIX_WIDTH-1:0] chan1;
      logic [PIX_WIDTH-1:0] chan2;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [PIX_WIDTH-1:0] out0;
      logic [PIX_WIDTH-1:0] out1;
      logic [PIX_WIDTH-1:0] out2;
      logic                 out_last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                      take;
      logic                      top_latch;
      logic                      div_load;
      logic                      div_step;
      logic                      gain_store;
      logic                      sums_clear;
      logic [CHAN_IDX_WIDTH-1:0] chan;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_blocked;
      logic frame_end;
   } status_type;

endpackage

/* hdl/gwb_ctrl.sv */
// ----------------------------------------------------------------------------
// gwb_ctrl
// Sequencer: streams pixels, then walks the gain division per channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gwb_pkg::status_type status,
   output gwb_pkg::cmd_type    cmd
);
   import gwb_pkg::*;

   typedef enum logic [4:0] {
      ST_RUN   = 5'b00001,
      ST_MAX   = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_STORE = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [CHAN_IDX_WIDTH-1:0] chan_ff, chan_in;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      chan_in        = chan_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.chan       = chan_ff;
      case (state_ff)
         ST_RUN: begin
            req_ready = !status.rsp_blocked;
            cmd.take  = req_valid && !status.rsp_blocked;
            if (cmd.take && status.frame_end) begin
               state_in = ST_MAX;
            end
         end
         ST_MAX: begin
            cmd.top_latch = 1'b1;
            chan_in       = '0;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.gain_store = 1'b1;
            if (chan_ff == LAST_CHAN) begin
               cmd.sums_clear = 1'b1;
               state_in       = ST_RUN;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff   <= '0;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

/* hdl/gwb_datapath.sv */
// ----------------------------------------------------------------------------
// gwb_datapath
// Channel sums, shared bit-serial gain divider, gain registers and apply path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwb_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gwb_pkg::cmd_type    cmd,
   output gwb_pkg::status_type status,
   input  gwb_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gwb_pkg::rsp_type    rsp_data
);
   import gwb_pkg::*;

   logic [SUM_WIDTH-1:0]  sums_ff  [NUM_CHAN];
   logic [SUM_WIDTH-1:0]  sums_in  [NUM_CHAN];
   logic [GAIN_WIDTH-1:0] gains_ff [NUM_CHAN];
   logic [GAIN_WIDTH-1:0] gains_in [NUM_CHAN];
   logic [PIX_WIDTH-1:0]  pix      [NUM_CHAN];
   logic [PIX_WIDTH-1:0]  scaled   [NUM_CHAN];

   logic [SUM_WIDTH-1:0]  top_ff, top_in;
   logic [DIV_STEPS-1:0]  num_ff, num_in;
   logic [SUM_WIDTH-1:0]  rem_ff, rem_in;
   logic [SUM_WIDTH-1:0]  divisor;
   logic [SUM_WIDTH:0]    trial;
   logic [SUM_WIDTH-1:0]  max01;
   logic [GAIN_WIDTH-1:0] gain_new;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign pix[0] = req_data.chan0;
   assign pix[1] = req_data.chan1;
   assign pix[2] = req_data.chan2;

   assign status.rsp_blocked = rsp_valid_ff && !rsp_ready;
   assign status.frame_end   = (req_data.op == OP_ACCUM) && req_data.last;

   assign divisor = sums_ff[cmd.chan];
   assign trial   = {rem_ff, num_ff[DIV_STEPS-1]};
   assign max01   = (sums_ff[1] > sums_ff[0]) ? sums_ff[1] : sums_ff[0];

   always_comb begin
      if (top_ff == '0) begin
         gain_new = GAIN_UNITY;
      end else if (divisor == '0) begin
         gain_new = GAIN_MAX;
      end else if (num_ff[DIV_STEPS-1:GAIN_WIDTH] != '0) begin
         gain_new = GAIN_MAX;
      end else begin
         gain_new = num_ff[GAIN_WIDTH-1:0];
      end
   end

   always_comb begin
      logic [SUM_WIDTH:0]    acc;
      logic [PROD_WIDTH-1:0] prod;
      logic [SCALED_WIDTH-1:0] shifted;
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc = {1'b0, sums_ff[c]} + (SUM_WIDTH+1)'(pix[c]);
         sums_in[c]  = sums_ff[c];
         gains_in[c] = gains_ff[c];
         if (cmd.sums_clear) begin
            sums_in[c] = '0;
         end else if (cmd.take && req_data.op == OP_ACCUM) begin
            sums_in[c] = (acc > {1'b0, SUM_CAP}) ? SUM_CAP : acc[SUM_WIDTH-1:0];
         end
         if (cmd.gain_store && cmd.chan == CHAN_IDX_WIDTH'(c)) begin
            gains_in[c] = gain_new;
         end
         prod      = PROD_WIDTH'(pix[c]) * PROD_WIDTH'(gains_ff[c]);
         shifted   = prod[PROD_WIDTH-1:GAIN_FRAC_BITS];
         scaled[c] = (shifted > SCALED_WIDTH'(PIX_MAX)) ? PIX_MAX
                                                         : shifted[PIX_WIDTH-1:0];
      end
   end

   // restoring division, one quotient bit per cycle, quotient shifts into num
   always_comb begin
      top_in = top_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      if (cmd.top_latch) begin
         top_in = (sums_ff[2] > max01) ? sums_ff[2] : max01;
      end
      if (cmd.div_load) begin
         num_in = {top_ff, GAIN_FRAC_BITS'(0)};
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = SUM_WIDTH'(trial - {1'b0, divisor});
            num_in = {num_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in = trial[SUM_WIDTH-1:0];
            num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.take && req_data.op == OP_APPLY) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out0     = scaled[0];
         rsp_in.out1     = scaled[1];
         rsp_in.out2     = scaled[2];
         rsp_in.out_last = req_data.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            sums_ff[c]  <= '0;
            gains_ff[c] <= GAIN_UNITY;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NUM_CHAN; c++) begin
            sums_ff[c]  <= sums_in[c];
            gains_ff[c] <= gains_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/gray_world_white_balance.sv */
// ----------------------------------------------------------------------------
// gray_world_white_balance
// Apply pixel: result registered the cycle after the transaction, one pixel
// per cycle while the output is not stalled. Accumulate pixel: one per cycle
// when not stalled, no result. After the last accumulate pixel input stalls
// for 1 max search + 3 x (load, 40 divider steps, store) on the single shared bit-serial divider.
// Synchronous reset clears the sums, sets unity gains and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gray_world_white_balance (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gwb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gwb_pkg::rsp_type rsp_data
);
   import gwb_pkg::*;

   cmd_type    cmd;
   status_type status;

   gwb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gwb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/gwb_checker.sv */
// ----------------------------------------------------------------------------
// gwb_checker
// Port-level checks for the white balance block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input gwb_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gwb_pkg::rsp_type rsp_data
);
   import gwb_pkg::*;

   logic req_take;
   assign req_take = req_valid && req_ready;

   // stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // every apply transaction gives a result next cycle carrying its last flag
   a_apply_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.op == OP_APPLY |=>
         rsp_valid && rsp_data.out_last == $past(req_data.last))
      else $error("apply transaction without matching result");

   // gain computation stalls the input after the last accumulate pixel
   a_frame_stall: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.op == OP_ACCUM && req_data.last |=> !req_ready)
      else $error("input accepted during gain computation");

   // accumulate transactions never create a result
   a_accum_quiet: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.op == OP_ACCUM && !rsp_valid |=> !rsp_valid)
      else $error("result produced by accumulate transaction");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gray_world_white_balance gwb_checker u_gwb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
